[rtl/core/rvalu_pkg.sv]
package rvalu_pkg;

    localparam int XLEN      = 32;
    localparam int FUNC_W    = 5;
    localparam int REG_IDX_W = 5;
    localparam int SHAMT_W   = 5;

    // One quotient bit is resolved in each divider stage.
    localparam int DIV_STEPS = XLEN;
    // Sideband line length: divider prep, its steps and its post stage.
    localparam int LINE_LEN  = DIV_STEPS + 2;

    typedef logic [FUNC_W-1:0] t_func;
    typedef logic [XLEN-1:0]   t_word;

    localparam t_func FN_ADD    = 5'd0;
    localparam t_func FN_SUB    = 5'd1;
    localparam t_func FN_XOR    = 5'd2;
    localparam t_func FN_OR     = 5'd3;
    localparam t_func FN_AND    = 5'd4;
    localparam t_func FN_SLL    = 5'd5;
    localparam t_func FN_SRL    = 5'd6;
    localparam t_func FN_SRA    = 5'd7;
    localparam t_func FN_SLT    = 5'd8;
    localparam t_func FN_SLTU   = 5'd9;
    localparam t_func FN_MUL    = 5'd10;
    localparam t_func FN_MULH   = 5'd11;
    localparam t_func FN_MULHSU = 5'd12;
    localparam t_func FN_MULHU  = 5'd13;
    localparam t_func FN_DIV    = 5'd14;
    localparam t_func FN_DIVU   = 5'd15;
    localparam t_func FN_REM    = 5'd16;
    localparam t_func FN_REMU   = 5'd17;

endpackage

[rtl/core/rvalu_mul.sv]
module rvalu_mul
    import rvalu_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_en,
    input  t_func i_func,
    input  t_word i_a,
    input  t_word i_b,
    output t_word o_result
);

    logic [2*XLEN-1:0] w_prod;
    logic [XLEN-1:0]   w_hi;
    logic [XLEN-1:0]   w_corr;

    // First stage: four half-width partial products and the signed correction.
    logic [XLEN-1:0] r_pp_ll, r_pp_lh, r_pp_hl, r_pp_hh, r_corr;
    logic            r_low;

    always_comb begin
        w_corr = '0;
        if (i_a[XLEN-1] && (i_func == FN_MULH || i_func == FN_MULHSU)) begin
            w_corr = i_b;
        end
        if (i_b[XLEN-1] && i_func == FN_MULH) begin
            w_corr = w_corr + i_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp_ll <= i_a[XLEN/2-1:0]    * i_b[XLEN/2-1:0];
            r_pp_lh <= i_a[XLEN/2-1:0]    * i_b[XLEN-1:XLEN/2];
            r_pp_hl <= i_a[XLEN-1:XLEN/2] * i_b[XLEN/2-1:0];
            r_pp_hh <= i_a[XLEN-1:XLEN/2] * i_b[XLEN-1:XLEN/2];
            r_corr  <= w_corr;
            r_low   <= (i_func == FN_MUL);
        end
    end

    // Second stage: sum the partial products and fix the high word.
    always_comb begin
        w_prod = {{XLEN{1'b0}}, r_pp_ll}
               + {{(XLEN/2){1'b0}}, r_pp_lh, {(XLEN/2){1'b0}}}
               + {{(XLEN/2){1'b0}}, r_pp_hl, {(XLEN/2){1'b0}}}
               + {r_pp_hh, {XLEN{1'b0}}};
        w_hi   = w_prod[2*XLEN-1:XLEN] - r_corr;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_result <= r_low ? w_prod[XLEN-1:0] : w_hi;
        end
    end

endmodule

[rtl/core/rvalu_div.sv]
module rvalu_div
    import rvalu_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_en,
    input  logic  i_signed,
    input  t_word i_a,
    input  t_word i_b,
    output t_word o_quot,
    output t_word o_rem
);

    t_word r_rem [0:DIV_STEPS];
    t_word r_quo [0:DIV_STEPS];
    t_word r_dvs [0:DIV_STEPS];
    t_word r_a   [0:DIV_STEPS];
    logic  r_nq  [0:DIV_STEPS];
    logic  r_nr  [0:DIV_STEPS];
    logic  r_dz  [0:DIV_STEPS];

    // Prep stage: operand magnitudes and the sign and zero flags.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= '0;
            r_quo[0] <= (i_signed && i_a[XLEN-1]) ? (~i_a + 1'b1) : i_a;
            r_dvs[0] <= (i_signed && i_b[XLEN-1]) ? (~i_b + 1'b1) : i_b;
            r_a[0]   <= i_a;
            r_nq[0]  <= i_signed && (i_a[XLEN-1] ^ i_b[XLEN-1]);
            r_nr[0]  <= i_signed && i_a[XLEN-1];
            r_dz[0]  <= (i_b == '0);
        end
    end

    // Restoring division: each stage shifts in one dividend bit and tries a subtract.
    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
        logic [XLEN:0] w_try;
        assign w_try = {r_rem[k-1], r_quo[k-1][XLEN-1]} - {1'b0, r_dvs[k-1]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!w_try[XLEN]) begin
                    r_rem[k] <= w_try[XLEN-1:0];
                end else begin
                    r_rem[k] <= {r_rem[k-1][XLEN-2:0], r_quo[k-1][XLEN-1]};
                end
                r_quo[k] <= {r_quo[k-1][XLEN-2:0], ~w_try[XLEN]};
                r_dvs[k] <= r_dvs[k-1];
                r_a[k]   <= r_a[k-1];
                r_nq[k]  <= r_nq[k-1];
                r_nr[k]  <= r_nr[k-1];
                r_dz[k]  <= r_dz[k-1];
            end
        end
    end

    // Post stage: restore signs; division by zero overrides both results.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_dz[DIV_STEPS]) begin
                o_quot <= '1;
                o_rem  <= r_a[DIV_STEPS];
            end else begin
                o_quot <= r_nq[DIV_STEPS] ? (~r_quo[DIV_STEPS] + 1'b1) : r_quo[DIV_STEPS];
                o_rem  <= r_nr[DIV_STEPS] ? (~r_rem[DIV_STEPS] + 1'b1) : r_rem[DIV_STEPS];
            end
        end
    end

endmodule

[rtl/core/rv32im_register_alu_top.sv]
// A transaction passes the input register, sideband line and output register.
// Throughput: one transaction per cycle unless held; the divider resolves one
// quotient bit per stage over 32 stages, and the multiplier takes two stages.
// The whole pipeline holds while a result waits under i_stall.
// Reset (synchronous, active low) clears all valid bits; data is not reset.
module rv32im_register_alu_top
    import rvalu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [FUNC_W-1:0]    i_func,
    input  logic [XLEN-1:0]      i_operand_a,
    input  logic [XLEN-1:0]      i_operand_b,
    input  logic [REG_IDX_W-1:0] i_dest_index,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [XLEN-1:0]      o_result_value,
    output logic                 o_write_enable,
    output logic [REG_IDX_W-1:0] o_dest_out
);

    logic w_en;
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    // Input register stage.
    logic                 r_in_valid;
    t_func                r_in_func;
    t_word                r_in_a, r_in_b;
    logic [REG_IDX_W-1:0] r_in_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_en) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in_func <= i_func;
            r_in_a    <= i_operand_a;
            r_in_b    <= i_operand_b;
            r_in_rd   <= i_dest_index;
        end
    end

    // Combinational operations.
    t_word              w_alu;
    logic [SHAMT_W-1:0] w_sh;

    always_comb begin
        w_sh = r_in_b[SHAMT_W-1:0];
        case (r_in_func)
            FN_ADD:  w_alu = r_in_a + r_in_b;
            FN_SUB:  w_alu = r_in_a - r_in_b;
            FN_XOR:  w_alu = r_in_a ^ r_in_b;
            FN_OR:   w_alu = r_in_a | r_in_b;
            FN_AND:  w_alu = r_in_a & r_in_b;
            FN_SLL:  w_alu = r_in_a << w_sh;
            FN_SRL:  w_alu = r_in_a >> w_sh;
            FN_SRA:  w_alu = t_word'($signed(r_in_a) >>> w_sh);
            FN_SLT:  w_alu = {{(XLEN-1){1'b0}}, ($signed(r_in_a) < $signed(r_in_b))};
            FN_SLTU: w_alu = {{(XLEN-1){1'b0}}, (r_in_a < r_in_b)};
            default: w_alu = '0;
        endcase
    end

    t_word w_mul, w_quot, w_rem;

    rvalu_mul u_mul (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_func   (r_in_func),
        .i_a      (r_in_a),
        .i_b      (r_in_b),
        .o_result (w_mul)
    );

    rvalu_div u_div (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_signed (r_in_func == FN_DIV || r_in_func == FN_REM),
        .i_a      (r_in_a),
        .i_b      (r_in_b),
        .o_quot   (w_quot),
        .o_rem    (w_rem)
    );

    // Sideband line, aligned stage for stage with the divider.
    logic                 r_sd_valid [0:LINE_LEN-1];
    t_func                r_sd_func  [0:LINE_LEN-1];
    logic [REG_IDX_W-1:0] r_sd_rd    [0:LINE_LEN-1];
    t_word                r_sd_res   [0:LINE_LEN-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LINE_LEN; k++) begin
                r_sd_valid[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_sd_valid[0] <= r_in_valid;
            for (int k = 1; k < LINE_LEN; k++) begin
                r_sd_valid[k] <= r_sd_valid[k-1];
            end
        end
    end

    logic w_is_mul;
    assign w_is_mul = (r_sd_func[1] == FN_MUL)    || (r_sd_func[1] == FN_MULH)
                   || (r_sd_func[1] == FN_MULHSU) || (r_sd_func[1] == FN_MULHU);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sd_func[0] <= r_in_func;
            r_sd_rd[0]   <= r_in_rd;
            r_sd_res[0]  <= w_alu;
            for (int k = 1; k < LINE_LEN; k++) begin
                r_sd_func[k] <= r_sd_func[k-1];
                r_sd_rd[k]   <= r_sd_rd[k-1];
                // The multiplier result joins the line once it is ready.
                if (k == 2 && w_is_mul) begin
                    r_sd_res[k] <= w_mul;
                end else begin
                    r_sd_res[k] <= r_sd_res[k-1];
                end
            end
        end
    end

    // Output register: pick the divider result for divide and remainder.
    t_func w_last_func;
    assign w_last_func = r_sd_func[LINE_LEN-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_en) begin
            o_valid <= r_sd_valid[LINE_LEN-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_last_func == FN_DIV || w_last_func == FN_DIVU) begin
                o_result_value <= w_quot;
            end else if (w_last_func == FN_REM || w_last_func == FN_REMU) begin
                o_result_value <= w_rem;
            end else begin
                o_result_value <= r_sd_res[LINE_LEN-1];
            end
            o_dest_out     <= r_sd_rd[LINE_LEN-1];
            o_write_enable <= (r_sd_rd[LINE_LEN-1] != '0);
        end
    end

    // The pipeline only holds when a finished result is waiting.
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("pipeline held without a pending result");

    // A transaction leaving the sideband line always reaches the output.
    a_line_to_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_sd_valid[LINE_LEN-1]) |=> o_valid)
        else $error("transaction lost at the output stage");

    // A write is never reported for register zero.
    a_no_write_x0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_write_enable) |-> (o_dest_out != '0))
        else $error("write enable raised for register zero");

endmodule

[bench/rv32im_register_alu_top_tb.sv]
module rv32im_register_alu_top_tb;
    import rvalu_pkg::*;

    // One expected ALU result.
    typedef struct packed {
        t_word                value;
        logic                 wen;
        logic [REG_IDX_W-1:0] rd;
    } t_alu_result;

    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 80;
    localparam t_word MIN_INT = 32'h8000_0000;
    localparam t_word ALL_ONES = 32'hFFFF_FFFF;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [FUNC_W-1:0]    i_func = '0;
    logic [XLEN-1:0]      i_operand_a = '0;
    logic [XLEN-1:0]      i_operand_b = '0;
    logic [REG_IDX_W-1:0] i_dest_index = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [XLEN-1:0]      o_result_value;
    logic                 o_write_enable;
    logic [REG_IDX_W-1:0] o_dest_out;

    t_alu_result pending_results[$];
    int mismatch_count = 0;
    int idle_cycles = 0;
    int stall_left = 0;
    bit timed_out = 1'b0;

    rv32im_register_alu_top dut (.*);

    always #5 i_clk = ~i_clk;

    // Absolute value of a two's complement word, as an unsigned word.
    function automatic t_word magnitude(input t_word v);
        return v[XLEN-1] ? -v : v;
    endfunction

    // Computes the architectural result of one RV32IM register operation.
    function automatic t_word alu_compute(input t_func fn, input t_word a, input t_word b);
        logic [63:0] prod;
        logic [63:0] prod_su;
        logic signed [63:0] prod_ss;
        t_word q;
        t_word r;
        prod = {32'b0, a} * {32'b0, b};
        prod_ss = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
        prod_su = {{32{a[31]}}, a} * {32'b0, b};
        case (fn)
            FN_ADD:    return a + b;
            FN_SUB:    return a - b;
            FN_XOR:    return a ^ b;
            FN_OR:     return a | b;
            FN_AND:    return a & b;
            FN_SLL:    return a << b[4:0];
            FN_SRL:    return a >> b[4:0];
            FN_SRA:    return t_word'($signed(a) >>> b[4:0]);
            FN_SLT:    return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            FN_SLTU:   return (a < b) ? 32'd1 : 32'd0;
            FN_MUL:    return prod[31:0];
            FN_MULH:   return prod_ss[63:32];
            FN_MULHSU: return prod_su[63:32];
            FN_MULHU:  return prod[63:32];
            FN_DIV: begin
                if (b == 0) return ALL_ONES;
                if (a == MIN_INT && b == ALL_ONES) return MIN_INT;
                q = magnitude(a) / magnitude(b);
                return (a[31] ^ b[31]) ? -q : q;
            end
            FN_DIVU:   return (b == 0) ? ALL_ONES : a / b;
            FN_REM: begin
                if (b == 0) return a;
                if (a == MIN_INT && b == ALL_ONES) return '0;
                r = magnitude(a) % magnitude(b);
                return a[31] ? -r : r;
            end
            FN_REMU:   return (b == 0) ? a : a % b;
            default:   return '0;
        endcase
    endfunction

    // Sends one transaction after a random gap and records its expected result.
    task automatic send_op(input t_func fn, input t_word a, input t_word b,
                           input logic [REG_IDX_W-1:0] rd);
        int gap;
        t_alu_result exp_res;
        gap = $urandom_range(0, 17);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= fn;
        i_operand_a <= a;
        i_operand_b <= b;
        i_dest_index <= rd;
        exp_res.value = alu_compute(fn, a, b);
        exp_res.wen = (rd != 0);
        exp_res.rd = rd;
        pending_results.push_back(exp_res);
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic finish_sending();
        i_valid <= 1'b0;
    endtask

    // Picks an operand that is often a corner value.
    function automatic t_word pick_operand();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return ALL_ONES;
            2: return MIN_INT;
            3: return 32'h7FFF_FFFF;
            4: return $urandom_range(0, 40);
            default: return $urandom;
        endcase
    endfunction

    // Directed corners: every operation, field extremes, division cases.
    task automatic test_directed();
        for (int f = 0; f <= FN_REMU; f++)
            send_op(t_func'(f), 32'hDEAD_BEEF, 32'h8765_4321, REG_IDX_W'(f + 1));
        send_op(FN_DIV, MIN_INT, ALL_ONES, 5'd31);
        send_op(FN_REM, MIN_INT, ALL_ONES, 5'd0);
        send_op(FN_DIV, 32'd7, 32'd0, 5'd3);
        send_op(FN_DIVU, 32'd7, 32'd0, 5'd3);
        send_op(FN_REM, 32'hFFFF_FFF9, 32'd0, 5'd3);
        send_op(FN_REMU, ALL_ONES, 32'd0, 5'd0);
        send_op(t_func'(31), ALL_ONES, ALL_ONES, 5'd9);
    endtask

    // Random operations, including undefined codes now and then.
    task automatic test_random(input int count);
        t_func fn;
        for (int n = 0; n < count; n++) begin
            fn = ($urandom_range(0, 15) == 0) ? t_func'($urandom_range(18, 31))
                                              : t_func'($urandom_range(0, 17));
            send_op(fn, pick_operand(), pick_operand(), REG_IDX_W'($urandom_range(0, 31)));
        end
    endtask

    // Receiver stall: after each accepted result, draw a random stall length and hold i_stall until it runs out.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else if (o_valid && !i_stall) begin
            stall_left = $urandom_range(0, 17);
            i_stall <= (stall_left != 0);
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_stall <= (stall_left != 0);
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_alu_result exp_res;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected transaction: value %h", o_result_value);
            end else begin
                exp_res = pending_results.pop_front();
                if (o_result_value !== exp_res.value || o_write_enable !== exp_res.wen
                    || o_dest_out !== exp_res.rd) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Mismatch: expected %h/%b/%0d, got %h/%b/%0d",
                                 exp_res.value, exp_res.wen, exp_res.rd,
                                 o_result_value, o_write_enable, o_dest_out);
                end
            end
        end
    end

    // Watchdog on cycles without any accepted transaction.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("rv32im_register_alu_top_tb NOT OK");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(940);
        finish_sending();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("rv32im_register_alu_top_tb OK");
        end else begin
            $display("rv32im_register_alu_top_tb NOT OK");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/rvalu_pkg.sv
rtl/core/rvalu_mul.sv
rtl/core/rvalu_div.sv
rtl/core/rv32im_register_alu_top.sv
bench/rv32im_register_alu_top_tb.sv
